// ===== src/prrts_pkg.sv =====
// ----------------------------------------------------------------------------
// prrts_pkg
// Types and constants shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package prrts_pkg;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_BLOCKED  = 3'd4
  } slot_status_t;

  typedef enum logic [2:0] {
    OP_INSTALL = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SLEEP   = 3'd2,
    OP_BLOCK   = 3'd3,
    OP_UNBLOCK = 3'd4,
    OP_TICK    = 3'd5,
    OP_SCHED   = 3'd6,
    OP_READ    = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,       // read addressed slot
    S_SINGLE,   // modify and write addressed slot
    S_SC_RD,    // schedule: issue read of slot i
    S_SC_UPD,   // schedule: update slot i, compare priority
    S_DEC,      // schedule: decide winner
    S_FIX_RD,   // read previous running slot
    S_FIX_WR,   // demote previous slot
    S_WIN_RD,   // read winner slot
    S_WIN_WR,   // promote winner
    S_OUT
  } state_t;

  typedef struct packed {
    slot_status_t status;
    logic [7:0]   prio;
    logic [31:0]  sleep_cnt;
    logic [31:0]  run_ticks;
  } slot_t;

  localparam slot_t SLOT_CLEAR = '{status: ST_FREE, prio: 8'd0,
                                   sleep_cnt: 32'd0, run_ticks: 32'd0};

  typedef struct packed {
    logic [3:0]  current_index;
    logic        current_valid;
    logic        switched;
    logic [3:0]  previous_index;
    logic        previous_valid;
    logic        yield_request;
    logic [31:0] run_ticks_value;
  } result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  task_index;
    logic        for_current;
    logic [7:0]  priority_req;
    logic [31:0] sleep_len;
  } request_t;

endpackage

// ===== src/prrts_if.sv =====
// ----------------------------------------------------------------------------
// prrts_req_if / prrts_res_if / prrts_cfg_if
// Valid-ready channels of the task scheduler.
// ----------------------------------------------------------------------------
interface prrts_req_if;
  logic                valid;
  logic                ready;
  prrts_pkg::request_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prrts_res_if;
  logic               valid;
  logic               ready;
  prrts_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prrts_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/prrts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// prrts_slot_mem
// Slot table memory, one write and one registered read port, with a
// fill-by-valid-bit reset (entries not yet written read as cleared).
// ----------------------------------------------------------------------------
module prrts_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  prrts_pkg::slot_t  wdata,
  input  logic [AW-1:0]     raddr,
  output prrts_pkg::slot_t  rdata
);
  import prrts_pkg::*;

  slot_t            mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  slot_t            rd_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rd_r : SLOT_CLEAR;
endmodule

// ===== src/prrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// prrts_ctrl
// Sequencer: single-slot read-modify-write for host ops, and a scan of
// all slots (wake, charge, pick) for schedule events while enabled.
// ----------------------------------------------------------------------------
module prrts_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enabled,
  input  logic                in_valid,
  output logic                in_ready,
  input  prrts_pkg::request_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prrts_pkg::result_t  out_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output prrts_pkg::slot_t    mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  prrts_pkg::slot_t    mem_rdata
);
  import prrts_pkg::*;

  state_t       state_r, state_nxt;
  request_t     req_r;
  logic [AW-1:0] run_slot_r, last_r, cnt_r, best_r, prev_slot_r, tgt_r;
  logic          run_vld_r, prev_vld_r, best_vld_r, tgt_ok_r;
  logic [7:0]    best_pri_r, run_prio_r;
  logic          sw_r, yld_r;
  logic [31:0]   rtv_r;
  logic [AW:0]   cnt_ext;
  logic [AW-1:0] idx_a, scan_a, in_tgt;
  logic          in_range;
  logic          sched_op;
  slot_t         s, upd;
  logic          eligible;

  assign idx_a    = AW'(req_r.task_index);
  assign in_range = ({28'd0, req_r.task_index} < 32'(DEPTH));
  assign sched_op = (req_r.op == OP_TICK || req_r.op == OP_SCHED);
  assign cnt_ext  = {1'b0, last_r} + {1'b0, cnt_r} + 1'b1;
  assign scan_a   = (cnt_ext >= (AW+1)'(DEPTH)) ?
                    AW'(cnt_ext - (AW+1)'(DEPTH)) : cnt_ext[AW-1:0];
  assign s        = mem_rdata;
  // only sleep and block may address the current task
  assign in_tgt   = ((in_data.op == OP_SLEEP || in_data.op == OP_BLOCK) &&
                     in_data.for_current) ? run_slot_r : AW'(in_data.task_index);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_RD;
      S_RD: begin
        if (sched_op) begin
          state_nxt = enabled ? S_SC_UPD : S_OUT;
        end else begin
          state_nxt = S_SINGLE;
        end
      end
      S_SINGLE: state_nxt = S_OUT;
      S_SC_RD:  state_nxt = S_SC_UPD;
      S_SC_UPD: state_nxt = (cnt_r == AW'(DEPTH-1)) ? S_DEC : S_SC_RD;
      S_DEC:    state_nxt = S_FIX_RD;
      S_FIX_RD: state_nxt = S_FIX_WR;
      S_FIX_WR: state_nxt = S_WIN_RD;
      S_WIN_RD: state_nxt = S_WIN_WR;
      S_WIN_WR: state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // slot update for the scan: wake sleepers, charge running task
  always_comb begin
    upd = s;
    if (req_r.op == OP_TICK && s.status == ST_SLEEPING && s.sleep_cnt != 32'd0) begin
      upd.sleep_cnt = s.sleep_cnt - 32'd1;
      if (s.sleep_cnt == 32'd1) upd.status = ST_READY;
    end
    if (run_vld_r && scan_a == run_slot_r) upd.run_ticks = s.run_ticks + 32'd1;
    eligible = (upd.status == ST_READY || upd.status == ST_RUNNING);
  end

  // outputs to memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_r;
    mem_wdata = s;
    mem_raddr = tgt_r;
    unique case (state_r)
      S_IDLE:   mem_raddr = in_tgt;
      // first scan slot is fetched while the request is decoded
      S_RD:     if (sched_op) mem_raddr = scan_a;
      S_SC_RD:  mem_raddr = scan_a;
      S_SC_UPD: begin
        mem_we = 1'b1; mem_waddr = scan_a; mem_wdata = upd;
      end
      S_SINGLE: begin
        mem_we = tgt_ok_r;
        unique case (op_t'(req_r.op))
          OP_INSTALL: begin
            mem_wdata = SLOT_CLEAR;
            mem_wdata.status = ST_READY;
            mem_wdata.prio = req_r.priority_req;
          end
          OP_REMOVE: mem_wdata = SLOT_CLEAR;
          OP_SLEEP: begin
            mem_wdata.status = ST_SLEEPING;
            mem_wdata.sleep_cnt = req_r.sleep_len;
          end
          OP_BLOCK:   mem_wdata.status = ST_BLOCKED;
          OP_UNBLOCK: mem_wdata.status = ST_READY;
          default:    mem_we = 1'b0;
        endcase
      end
      S_FIX_RD: mem_raddr = prev_slot_r;
      S_FIX_WR: begin
        mem_waddr = prev_slot_r;
        mem_wdata.status = ST_READY;
        mem_we = prev_vld_r && s.status == ST_RUNNING &&
                 (!best_vld_r || best_r != prev_slot_r);
      end
      S_WIN_RD: mem_raddr = best_r;
      S_WIN_WR: begin
        mem_waddr = best_r;
        mem_wdata.status = ST_RUNNING;
        mem_we = best_vld_r && (!prev_vld_r || best_r != prev_slot_r);
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  always_comb begin
    out_data.current_index   = 4'(run_slot_r);
    out_data.current_valid   = run_vld_r;
    out_data.switched        = sw_r;
    out_data.previous_index  = sched_op ? 4'(prev_slot_r) : 4'(run_slot_r);
    out_data.previous_valid  = sched_op ? prev_vld_r : run_vld_r;
    out_data.yield_request   = yld_r;
    out_data.run_ticks_value = rtv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      run_slot_r <= '0;
      run_vld_r  <= 1'b0;
      last_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_SINGLE: if (req_r.op == OP_REMOVE && in_range && run_vld_r &&
                      run_slot_r == idx_a)
                    run_vld_r <= 1'b0;
        S_DEC: begin
          if (best_vld_r) begin
            last_r     <= best_r;
            run_slot_r <= best_r;
          end
          run_vld_r <= best_vld_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        req_r       <= in_data;
        prev_slot_r <= run_slot_r;
        prev_vld_r  <= run_vld_r;
        cnt_r       <= '0;
        best_vld_r  <= 1'b0;
        best_pri_r  <= '0;
        sw_r        <= 1'b0;
        yld_r       <= 1'b0;
        rtv_r       <= '0;
        tgt_r       <= in_tgt;
      end
      S_RD: begin
        // unblock compares against the priority kept for the running slot
        unique case (op_t'(req_r.op))
          OP_INSTALL: tgt_ok_r <= in_range && s.status == ST_FREE;
          OP_REMOVE:  tgt_ok_r <= in_range;
          OP_SLEEP, OP_BLOCK: begin
            tgt_ok_r <= (req_r.for_current ? run_vld_r : in_range) &&
                        s.status != ST_FREE;
            yld_r    <= enabled && (req_r.for_current ? run_vld_r : in_range) &&
                        s.status != ST_FREE;
          end
          OP_UNBLOCK: begin
            tgt_ok_r <= in_range && s.status != ST_FREE && s.status != ST_RUNNING;
            yld_r    <= enabled && run_vld_r && in_range && s.status != ST_FREE &&
                        s.status != ST_RUNNING && s.prio > run_prio_r;
          end
          OP_READ: begin
            tgt_ok_r <= 1'b0;
            if (in_range) rtv_r <= s.run_ticks;
          end
          default: tgt_ok_r <= 1'b0;
        endcase
      end
      S_SC_UPD: begin
        cnt_r <= cnt_r + 1'b1;
        if (eligible && (!best_vld_r || upd.prio > best_pri_r)) begin
          best_vld_r <= 1'b1;
          best_pri_r <= upd.prio;
          best_r     <= scan_a;
        end
      end
      S_DEC: sw_r <= best_vld_r ? (!run_vld_r || run_slot_r != best_r) : run_vld_r;
      default: ;
    endcase
  end

  // priority of the running slot, kept alongside it
  always_ff @(posedge clk) begin
    if (state_r == S_DEC && best_vld_r) run_prio_r <= best_pri_r;
  end
endmodule

// ===== src/priority_round_robin_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_core
// Priority round-robin task scheduler over a slot table in memory.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | op, task_index, for_current, priority_req, sleep_len
// out_    | out | current/previous index and valid, switched, yield, ticks
// cfg_    | in  | scheduler_enabled
// Host ops: slot read, write, result.
// Schedule events: a scan of every slot while enabled, then demote previous, promote winner.
// Reset clears control; table entries read as free until first written.
// A stalled result holds the block until taken.
module priority_round_robin_task_scheduler_core #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  prrts_req_if.sink           in_ch,
  prrts_res_if.source         out_ch,
  prrts_cfg_if.sink           cfg_ch
);
  import prrts_pkg::*;
  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic       en_r;
  logic       we;
  logic [AW-1:0] wa, ra;
  slot_t      wd, rd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) en_r <= 1'b0;
    else if (cfg_ch.valid) en_r <= cfg_ch.data;
  end

  prrts_slot_mem #(.DEPTH(TASK_SLOTS), .AW(AW)) u_mem (
    .clk, .rst_n, .we, .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

  prrts_ctrl #(.DEPTH(TASK_SLOTS), .AW(AW)) u_ctrl (
    .clk, .rst_n, .enabled(en_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .mem_we(we), .mem_waddr(wa), .mem_wdata(wd), .mem_raddr(ra), .mem_rdata(rd));
endmodule

// ===== tb/sv/prrts_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prrts_scoreboard
// Shadow scheduler and result queue for the task scheduler testbench.
// ----------------------------------------------------------------------------
class prrts_scoreboard;
  prrts_pkg::slot_status_t st [16];
  logic [7:0]  pri [16];
  logic [31:0] slp [16];
  logic [31:0] rt  [16];
  logic [3:0]  run_slot;
  logic        run_ok;
  logic [3:0]  last_pick;
  logic        enabled;
  prrts_pkg::result_t pending [$];
  int errors;
  int checked;

  function void clear_all();
    for (int i = 0; i < 16; i++) begin
      st[i] = prrts_pkg::ST_FREE;
      pri[i] = '0;
      slp[i] = '0;
      rt[i] = '0;
    end
    run_slot = '0;
    run_ok = 1'b0;
    last_pick = '0;
    enabled = 1'b0;
    errors = 0;
    checked = 0;
  endfunction

  function void wipe(int s);
    st[s] = prrts_pkg::ST_FREE;
    pri[s] = '0;
    slp[s] = '0;
    rt[s] = '0;
  endfunction

  function logic run_sched(bit tick);
    int best_pri;
    logic [3:0] best;
    logic [3:0] s;
    best_pri = -1;
    best = '0;
    if (tick) begin
      for (int i = 0; i < 16; i++)
        if (st[i] == prrts_pkg::ST_SLEEPING && slp[i] != 0) begin
          slp[i] = slp[i] - 1;
          if (slp[i] == 0) st[i] = prrts_pkg::ST_READY;
        end
    end
    if (run_ok) rt[run_slot] = rt[run_slot] + 1;
    for (int i = 0; i < 16; i++) begin
      s = last_pick + 4'd1 + 4'(i);
      if ((st[s] == prrts_pkg::ST_READY || st[s] == prrts_pkg::ST_RUNNING) &&
          int'(pri[s]) > best_pri) begin
        best_pri = pri[s];
        best = s;
      end
    end
    if (best_pri < 0) begin
      if (run_ok) begin
        if (st[run_slot] == prrts_pkg::ST_RUNNING) st[run_slot] = prrts_pkg::ST_READY;
        run_ok = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    last_pick = best;
    if (!run_ok || run_slot != best) begin
      if (run_ok && st[run_slot] == prrts_pkg::ST_RUNNING)
        st[run_slot] = prrts_pkg::ST_READY;
      st[best] = prrts_pkg::ST_RUNNING;
      run_slot = best;
      run_ok = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Note an accepted request and queue its expected result.
  function void note_request(prrts_pkg::request_t r);
    prrts_pkg::result_t e;
    logic [3:0] tgt;
    logic has;
    e = '0;
    e.previous_index = run_slot;
    e.previous_valid = run_ok;
    has = 1'b0;
    tgt = r.task_index;
    if (r.op == prrts_pkg::OP_SLEEP || r.op == prrts_pkg::OP_BLOCK) begin
      if (r.for_current) begin
        has = run_ok;
        tgt = run_slot;
      end else has = 1'b1;
      if (has && st[tgt] == prrts_pkg::ST_FREE) has = 1'b0;
    end
    case (prrts_pkg::op_t'(r.op))
      prrts_pkg::OP_INSTALL: if (st[r.task_index] == prrts_pkg::ST_FREE) begin
        wipe(r.task_index);
        st[r.task_index] = prrts_pkg::ST_READY;
        pri[r.task_index] = r.priority_req;
      end
      prrts_pkg::OP_REMOVE: begin
        wipe(r.task_index);
        if (run_ok && run_slot == r.task_index) run_ok = 1'b0;
      end
      prrts_pkg::OP_SLEEP: if (has) begin
        st[tgt] = prrts_pkg::ST_SLEEPING;
        slp[tgt] = r.sleep_len;
        e.yield_request = enabled;
      end
      prrts_pkg::OP_BLOCK: if (has) begin
        st[tgt] = prrts_pkg::ST_BLOCKED;
        e.yield_request = enabled;
      end
      prrts_pkg::OP_UNBLOCK: if (st[r.task_index] != prrts_pkg::ST_FREE &&
                                 st[r.task_index] != prrts_pkg::ST_RUNNING) begin
        st[r.task_index] = prrts_pkg::ST_READY;
        e.yield_request = enabled && run_ok && pri[r.task_index] > pri[run_slot];
      end
      prrts_pkg::OP_TICK, prrts_pkg::OP_SCHED:
        if (enabled) e.switched = run_sched(r.op == prrts_pkg::OP_TICK);
      default: e.run_ticks_value = rt[r.task_index];
    endcase
    if (r.op != prrts_pkg::OP_TICK && r.op != prrts_pkg::OP_SCHED) begin
      e.previous_index = run_slot;
      e.previous_valid = run_ok;
    end
    e.current_index = run_slot;
    e.current_valid = run_ok;
    pending.push_back(e);
  endfunction

  function void check_result(prrts_pkg::result_t a);
    prrts_pkg::result_t e;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", a);
      return;
    end
    e = pending.pop_front();
    if (a !== e) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
    end
  endfunction
endclass

// ===== tb/sv/priority_round_robin_task_scheduler_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_core_test
// Drives random and directed requests with random gaps on both channels and
// checks every result against a shadow scheduler.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_core_test;
  import prrts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  prrts_req_if in_ch ();
  prrts_res_if out_ch ();
  prrts_cfg_if cfg_ch ();
  prrts_scoreboard sched_model;
  int sent;
  bit input_done;

  priority_round_robin_task_scheduler_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // valid stays high into a back-to-back request; dropped only across a gap
  task automatic send_request(request_t r);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    sched_model.note_request(r);
    sent++;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_op(op_t op, int idx, bit cur, int p, logic [31:0] t);
    request_t r;
    r.op = op;
    r.task_index = 4'(idx);
    r.for_current = cur;
    r.priority_req = 8'(p);
    r.sleep_len = t;
    send_request(r);
  endtask

  // Config writes only with no results outstanding.
  task automatic write_enable(bit v);
    in_ch.valid <= 1'b0;
    while (sched_model.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sched_model.enabled = v;
  endtask

  task automatic random_request();
    request_t r;
    int k;
    r = request_t'(48'({$urandom, $urandom}));
    k = $urandom_range(0, 99);
    if (k < 15) r.op = OP_INSTALL;
    else if (k < 20) r.op = OP_REMOVE;
    else if (k < 30) r.op = OP_SLEEP;
    else if (k < 38) r.op = OP_BLOCK;
    else if (k < 50) r.op = OP_UNBLOCK;
    else if (k < 75) r.op = OP_TICK;
    else if (k < 88) r.op = OP_SCHED;
    else r.op = OP_READ;
    if (r.op == OP_SLEEP && $urandom_range(0, 3) != 0) r.sleep_len = $urandom_range(0, 6);
    if ($urandom_range(0, 2) == 0) r.priority_req = 8'($urandom_range(0, 3));
    send_request(r);
  endtask

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sched_model.check_result(out_ch.data);
  end

  initial begin
    int n;
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    sched_model = new();
    sched_model.clear_all();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: disabled edits, then enabled extremes
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_INSTALL, 0, 0, 255, 0);
    send_op(OP_INSTALL, 15, 0, 0, 0);
    send_op(OP_INSTALL, 0, 0, 9, 0);
    send_op(OP_SLEEP, 3, 0, 0, 5);
    send_op(OP_SLEEP, 0, 1, 0, 5);
    write_enable(1'b1);
    send_op(OP_SCHED, 0, 0, 0, 0);
    send_op(OP_INSTALL, 5, 0, 255, 0);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 0);
    send_op(OP_SLEEP, 0, 1, 0, 32'hFFFF_FFFF);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_SLEEP, 0, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_BLOCK, 0, 1, 0, 0);
    send_op(OP_UNBLOCK, 0, 0, 0, 0);
    send_op(OP_UNBLOCK, 15, 0, 0, 0);
    send_op(OP_SCHED, 0, 0, 0, 0);
    send_op(OP_REMOVE, 5, 0, 0, 0);
    send_op(OP_READ, 5, 0, 0, 0);
    send_op(OP_REMOVE, 15, 0, 0, 0);
    send_op(OP_SCHED, 0, 0, 0, 0);
    send_op(OP_READ, 15, 0, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph != 1);
      for (int i = 0; i < 135; i++) random_request();
    end
    in_ch.valid <= 1'b0;
    input_done = 1'b1;
  end

  initial begin
    wait (input_done);
    while (sched_model.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, enabled and disabled phases.",
             sent, sched_model.checked);
    if (sched_model.errors == 0 && sched_model.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end
endmodule
